[rtl/core/mips_branch_resolve_unit_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the branch resolve unit
// Shared property forms; each expands to a labeled concurrent assertion.
// -----------------------------------------------------------------------------
`ifndef MIPS_BRANCH_RESOLVE_UNIT_ASSERT_SVH
`define MIPS_BRANCH_RESOLVE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mbr_pkg.sv]
// -----------------------------------------------------------------------------
// mbr_pkg
// Types and constants shared by the branch resolve unit.
// -----------------------------------------------------------------------------
package mbr_pkg;

    localparam int FRACTION_BITS = 3;
    localparam int PENDING_W     = 32;
    localparam int COUNTER_W     = 64;
    localparam int WHOLE_W       = PENDING_W - FRACTION_BITS;
    localparam int COST_W        = 16;

    localparam logic [4:0]  LINK_REG    = 5'd31;
    localparam logic [31:0] WORD_BYTES  = 32'd4;
    localparam logic [31:0] LINK_OFFSET = 32'd8;

    typedef enum logic [4:0] {
        CMD_J       = 5'd0,
        CMD_JAL     = 5'd1,
        CMD_BEQ     = 5'd2,
        CMD_BNE     = 5'd3,
        CMD_BGEZ    = 5'd4,
        CMD_BGEZAL  = 5'd5,
        CMD_BGTZ    = 5'd6,
        CMD_BLEZ    = 5'd7,
        CMD_BLTZ    = 5'd8,
        CMD_BLTZAL  = 5'd9,
        CMD_BEQL    = 5'd10,
        CMD_BNEL    = 5'd11,
        CMD_BLEZL   = 5'd12,
        CMD_BGTZL   = 5'd13,
        CMD_BLTZL   = 5'd14,
        CMD_BGEZL   = 5'd15,
        CMD_BLTZALL = 5'd16,
        CMD_BGEZALL = 5'd17,
        CMD_JR      = 5'd18,
        CMD_JALR    = 5'd19
    } cmd_t;

    typedef struct packed {
        logic [4:0]         command;
        logic [31:0]        branch_address;
        logic signed [63:0] rs_value;
        logic signed [63:0] rt_value;
        logic signed [15:0] offset;
        logic [25:0]        jump_index;
        logic [4:0]         dest_index;
        logic [COST_W-1:0]  cost_eighths;
    } req_t;

    typedef struct packed {
        logic                 taken;
        logic [31:0]          resume_address;
        logic                 slot_runs;
        logic                 link_write;
        logic [4:0]           link_register;
        logic [31:0]          link_value;
        logic [COUNTER_W-1:0] cycle_total;
    } rsp_t;

    // Resolved branch outcome, everything but the cycle count.
    typedef struct packed {
        logic        taken;
        logic [31:0] resume_address;
        logic        slot_runs;
        logic        link_write;
        logic [4:0]  link_register;
        logic [31:0] link_value;
    } res_t;

endpackage

[rtl/core/mbr_decode.sv]
// -----------------------------------------------------------------------------
// mbr_decode
// Condition test, target select and link decision for one branch beat.
// -----------------------------------------------------------------------------
module mbr_decode (
    input  mbr_pkg::req_t req,
    output mbr_pkg::res_t res
);

    logic [31:0] next_pc;
    logic [31:0] seq_pc;
    logic [31:0] br_target;
    logic [31:0] j_target;
    logic [31:0] r_target;
    logic        rs_zero;
    logic        rs_neg;
    logic        rs_eq_rt;
    logic        cond;
    logic        likely;
    logic        link;
    logic [31:0] target;
    logic [4:0]  link_reg;

    assign next_pc   = req.branch_address + mbr_pkg::WORD_BYTES;
    assign seq_pc    = req.branch_address + mbr_pkg::LINK_OFFSET;
    assign br_target = next_pc + {{14{req.offset[15]}}, req.offset, 2'b00};
    assign j_target  = {next_pc[31:28], req.jump_index, 2'b00};
    assign r_target  = req.rs_value[31:0];

    assign rs_zero  = (req.rs_value == 64'sd0);
    assign rs_neg   = req.rs_value[63];
    assign rs_eq_rt = (req.rs_value == req.rt_value);

    always_comb
    begin
        cond     = 1'b0;
        likely   = 1'b0;
        link     = 1'b0;
        target   = br_target;
        link_reg = mbr_pkg::LINK_REG;
        case (req.command)
            mbr_pkg::CMD_J:
            begin
                cond   = 1'b1;
                target = j_target;
            end
            mbr_pkg::CMD_JAL:
            begin
                cond   = 1'b1;
                target = j_target;
                link   = 1'b1;
            end
            mbr_pkg::CMD_BEQ:     cond = rs_eq_rt;
            mbr_pkg::CMD_BNE:     cond = !rs_eq_rt;
            mbr_pkg::CMD_BGEZ:    cond = !rs_neg;
            mbr_pkg::CMD_BGEZAL:
            begin
                cond = !rs_neg;
                link = 1'b1;
            end
            mbr_pkg::CMD_BGTZ:    cond = !rs_neg && !rs_zero;
            mbr_pkg::CMD_BLEZ:    cond = rs_neg || rs_zero;
            mbr_pkg::CMD_BLTZ:    cond = rs_neg;
            mbr_pkg::CMD_BLTZAL:
            begin
                cond = rs_neg;
                link = 1'b1;
            end
            mbr_pkg::CMD_BEQL:
            begin
                cond   = rs_eq_rt;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BNEL:
            begin
                cond   = !rs_eq_rt;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BLEZL:
            begin
                cond   = rs_neg || rs_zero;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BGTZL:
            begin
                cond   = !rs_neg && !rs_zero;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BLTZL:
            begin
                cond   = rs_neg;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BGEZL:
            begin
                cond   = !rs_neg;
                likely = 1'b1;
            end
            mbr_pkg::CMD_BLTZALL:
            begin
                cond   = rs_neg;
                likely = 1'b1;
                link   = 1'b1;
            end
            mbr_pkg::CMD_BGEZALL:
            begin
                cond   = !rs_neg;
                likely = 1'b1;
                link   = 1'b1;
            end
            mbr_pkg::CMD_JR:
            begin
                cond   = 1'b1;
                target = r_target;
            end
            mbr_pkg::CMD_JALR:
            begin
                cond     = 1'b1;
                target   = r_target;
                link_reg = req.dest_index;
                link     = (req.dest_index != 5'd0);
            end
            // unknown codes: plain not-taken branch
            default:
            begin
                cond = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.taken          = cond;
        res.resume_address = cond ? target : seq_pc;
        res.slot_runs      = !(likely && !cond);
        // drop the link on a branch that falls through
        res.link_write     = link && cond;
        res.link_register  = (link && cond) ? link_reg : 5'd0;
        res.link_value     = (link && cond) ? seq_pc : 32'd0;
    end

endmodule

[rtl/core/mbr_cost_acc.sv]
// -----------------------------------------------------------------------------
// mbr_cost_acc
// Fixed-point cost accumulator and wrapping whole-cycle counter.
// -----------------------------------------------------------------------------
module mbr_cost_acc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic                                taken,
    input  logic [mbr_pkg::COST_W-1:0]          cost_eighths,
    output logic [mbr_pkg::COUNTER_W-1:0]       cycle_total
);

    logic [mbr_pkg::PENDING_W-1:0] pending_reg;
    logic [mbr_pkg::PENDING_W-1:0] pending_next;
    logic [mbr_pkg::COUNTER_W-1:0] counter_reg;
    logic [mbr_pkg::COUNTER_W-1:0] counter_next;
    logic [mbr_pkg::PENDING_W-1:0] pending_sum;
    logic [mbr_pkg::WHOLE_W-1:0]   whole;

    assign pending_sum = pending_reg
                       + {{(mbr_pkg::PENDING_W - mbr_pkg::COST_W){1'b0}}, cost_eighths};
    assign whole       = pending_sum[mbr_pkg::PENDING_W-1:mbr_pkg::FRACTION_BITS];

    always_comb
    begin
        pending_next = pending_sum;
        counter_next = counter_reg;
        if (taken)
        begin
            // fold whole cycles, keep the fraction
            counter_next = counter_reg
                         + {{(mbr_pkg::COUNTER_W - mbr_pkg::WHOLE_W){1'b0}}, whole};
            pending_next = {{(mbr_pkg::PENDING_W - mbr_pkg::FRACTION_BITS){1'b0}},
                            pending_sum[mbr_pkg::FRACTION_BITS-1:0]};
        end
    end

    assign cycle_total = counter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            counter_reg <= '0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            counter_reg <= counter_next;
        end
    end

endmodule

[rtl/core/mips_branch_resolve_unit.sv]
// -----------------------------------------------------------------------------
// mips_branch_resolve_unit
// Branch and jump resolution with likely-branch annul and cycle accounting.
// -----------------------------------------------------------------------------
// The unit takes one branch beat per clock unless the result side stalls. An
// accepted beat lands in the input register; its result beat then moves into
// the result register and is offered from there, leaving once the result side
// accepts it. The condition test, target select, cost accumulator and 64-bit
// cycle counter all work on the input register as the beat moves into the
// result register, so each result carries the counter value after that
// branch. Both registers hold under back-pressure, and a new beat is taken
// whenever the input register is empty or moving forward.
module mips_branch_resolve_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mbr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mbr_pkg::rsp_t rsp
);

    mbr_pkg::res_t   dec_res;
    mbr_pkg::req_t   s1_reg;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    mbr_pkg::rsp_t   rsp_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    logic            advance;
    logic            req_fire;
    logic [mbr_pkg::COUNTER_W-1:0] cycle_total;

    mbr_decode u_decode (
        .req (s1_reg),
        .res (dec_res)
    );

    mbr_cost_acc u_cost_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .taken        (dec_res.taken),
        .cost_eighths (s1_reg.cost_eighths),
        .cycle_total  (cycle_total)
    );

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg <= req;
        end
        if (advance)
        begin
            rsp_reg.taken          <= dec_res.taken;
            rsp_reg.resume_address <= dec_res.resume_address;
            rsp_reg.slot_runs      <= dec_res.slot_runs;
            rsp_reg.link_write     <= dec_res.link_write;
            rsp_reg.link_register  <= dec_res.link_register;
            rsp_reg.link_value     <= dec_res.link_value;
            rsp_reg.cycle_total    <= cycle_total;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/core/mbr_checker.sv]
// -----------------------------------------------------------------------------
// mbr_checker
// Port-level checks on the branch resolve unit, bound to the top level.
// -----------------------------------------------------------------------------
`include "mips_branch_resolve_unit_assert.svh"

module mbr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input mbr_pkg::rsp_t rsp
);

    // hold a stalled result beat
    `MBR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result beat dropped or changed while stalled")

    `MBR_ASSERT_NOW(a_link_needs_taken, rsp_valid && rsp.link_write, rsp.taken, "link written on a branch that was not taken")

    `MBR_ASSERT_NOW(a_annul_not_taken, rsp_valid && !rsp.slot_runs, !rsp.taken, "delay slot annulled on a taken branch")

    `MBR_ASSERT_NOW(a_no_link_zero, rsp_valid && !rsp.link_write, (rsp.link_register == 5'd0) && (rsp.link_value == 32'd0), "link fields not cleared without a link write")

    // input stalls only behind a stalled result beat
    `MBR_ASSERT_NOW(a_ready_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled without back-pressure")

endmodule

bind mips_branch_resolve_unit mbr_checker u_mbr_checker (.*);
